[hdl/spm_pkg.sv]
// Shared types and constants of the servo pulse elevon mixer.
package spm_pkg;

    typedef logic [15:0] tick_t;
    typedef logic [16:0] mix_t;
    typedef logic [7:0]  cfg_index_t;

    typedef enum logic [7:0] {
        REG_FRAME_TICKS  = 8'd0,
        REG_PULSE_MIN    = 8'd1,
        REG_PULSE_MAX    = 8'd2,
        REG_PULSE_CENTER = 8'd3
    } cfg_reg_t;

    localparam tick_t FRAME_TICKS_RST  = 16'd2000;
    localparam tick_t PULSE_MIN_RST    = 16'd100;
    localparam tick_t PULSE_MAX_RST    = 16'd220;
    localparam tick_t PULSE_CENTER_RST = 16'd150;
    localparam tick_t COUNT_MAX        = 16'hFFFF;

endpackage

[hdl/spm_sample_if.sv]
// Channel carrying one tick of sampled servo input levels.
interface spm_sample_if;
    logic valid;
    logic ready;
    logic elevator_level;
    logic aileron_level;

    modport source (output valid, output elevator_level, output aileron_level, input ready);
    modport sink (input valid, input elevator_level, input aileron_level, output ready);
endinterface

[hdl/spm_drive_if.sv]
// Channel carrying one tick of servo output pin levels.
interface spm_drive_if;
    logic valid;
    logic ready;
    logic left_level;
    logic right_level;

    modport source (output valid, output left_level, output right_level, input ready);
    modport sink (input valid, input left_level, input right_level, output ready);
endinterface

[hdl/spm_cfg_if.sv]
// Configuration write channel: register index and write data.
interface spm_cfg_if;
    logic                valid;
    logic                ready;
    spm_pkg::cfg_index_t index;
    spm_pkg::tick_t      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/servo_pulse_elevon_mixer.sv]
// Elevon mixer: measures two servo pulse inputs and drives two mixed servo outputs.
//
//   channel  | role | payload
//   ---------+------+-----------------------------------------
//   sample   | sink | elevator_level, aileron_level (one tick)
//   drive    | src  | left_level, right_level (one per tick)
//   cfg      | sink | index, data (register write)
//
// Each item's result is registered into the output register in the cycle after it is taken.
// One item per cycle with drive ready; mixing adders and width compares set the clock path.
// A new item is taken whenever the output register is empty or is being emptied.
// Reset restores the register defaults and clears all counters, widths and the output.
// Configuration writes are always taken.
module servo_pulse_elevon_mixer (
    input  logic          clk,
    input  logic          rst_n,
    spm_sample_if.sink    sample,
    spm_drive_if.source   drive,
    spm_cfg_if.sink       cfg
);
    import spm_pkg::*;

    tick_t frame_ticks_reg, pulse_min_reg, pulse_max_reg, pulse_center_reg;
    tick_t elev_count_reg, elev_count_next, ail_count_reg, ail_count_next;
    tick_t elev_width_reg, elev_width_next, ail_width_reg, ail_width_next;
    tick_t frame_count_reg, frame_count_next, frame_inc;
    mix_t  left_width_reg, left_width_next, right_width_reg, right_width_next;
    logic  out_valid_reg, left_level_reg, left_level_next, right_level_reg, right_level_next;

    logic        accept, wrap, mix_ok;
    logic signed [16:0] elev_diff, ail_diff, elev_adj, ail_adj, elev_half, ail_half;
    logic signed [18:0] left_sum, right_sum, center_ext;

    assign sample.ready = !out_valid_reg || drive.ready;
    assign accept       = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign drive.valid       = out_valid_reg;
    assign drive.left_level  = left_level_reg;
    assign drive.right_level = right_level_reg;

    always_comb
    begin
        // Pulse width measurement: count high ticks, latch on the first low tick.
        elev_count_next = elev_count_reg;
        elev_width_next = elev_width_reg;
        if (sample.elevator_level)
        begin
            if (elev_count_reg != COUNT_MAX)
                elev_count_next = elev_count_reg + 16'd1;
        end
        else if (elev_count_reg != '0)
        begin
            elev_width_next = elev_count_reg;
            elev_count_next = '0;
        end

        ail_count_next = ail_count_reg;
        ail_width_next = ail_width_reg;
        if (sample.aileron_level)
        begin
            if (ail_count_reg != COUNT_MAX)
                ail_count_next = ail_count_reg + 16'd1;
        end
        else if (ail_count_reg != '0)
        begin
            ail_width_next = ail_count_reg;
            ail_count_next = '0;
        end

        // Mixing of the freshly updated widths; halving rounds toward zero.
        mix_ok = elev_width_next >= pulse_min_reg && elev_width_next <= pulse_max_reg &&
                 ail_width_next >= pulse_min_reg && ail_width_next <= pulse_max_reg;
        elev_diff  = $signed({1'b0, elev_width_next}) - $signed({1'b0, pulse_center_reg});
        ail_diff   = $signed({1'b0, ail_width_next}) - $signed({1'b0, pulse_center_reg});
        elev_adj   = elev_diff + $signed({16'd0, elev_diff[16]});
        ail_adj    = ail_diff + $signed({16'd0, ail_diff[16]});
        elev_half  = elev_adj >>> 1;
        ail_half   = ail_adj >>> 1;
        center_ext = $signed({3'b000, pulse_center_reg});
        left_sum   = $signed({{2{elev_half[16]}}, elev_half})
                   + $signed({{2{ail_half[16]}}, ail_half}) + center_ext;
        right_sum  = $signed({{2{elev_half[16]}}, elev_half})
                   - $signed({{2{ail_half[16]}}, ail_half}) + center_ext;

        frame_inc = frame_count_reg + 16'd1;
        wrap      = (frame_inc == frame_ticks_reg);

        left_width_next  = left_width_reg;
        right_width_next = right_width_reg;
        if (wrap)
        begin
            frame_count_next = '0;
            if (mix_ok)
            begin
                left_width_next  = left_sum[18] ? '0 : left_sum[16:0];
                right_width_next = right_sum[18] ? '0 : right_sum[16:0];
            end
            else
            begin
                left_width_next  = '0;
                right_width_next = '0;
            end
        end
        else
        begin
            frame_count_next = frame_inc;
        end

        left_level_next  = {1'b0, frame_count_next} < left_width_next;
        right_level_next = {1'b0, frame_count_next} < right_width_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ticks_reg  <= FRAME_TICKS_RST;
            pulse_min_reg    <= PULSE_MIN_RST;
            pulse_max_reg    <= PULSE_MAX_RST;
            pulse_center_reg <= PULSE_CENTER_RST;
            elev_count_reg   <= '0;
            ail_count_reg    <= '0;
            elev_width_reg   <= '0;
            ail_width_reg    <= '0;
            frame_count_reg  <= '0;
            left_width_reg   <= '0;
            right_width_reg  <= '0;
            out_valid_reg    <= 1'b0;
            left_level_reg   <= 1'b0;
            right_level_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_FRAME_TICKS:  frame_ticks_reg  <= cfg.data;
                    REG_PULSE_MIN:    pulse_min_reg    <= cfg.data;
                    REG_PULSE_MAX:    pulse_max_reg    <= cfg.data;
                    REG_PULSE_CENTER: pulse_center_reg <= cfg.data;
                    default:          ;
                endcase
            end

            if (accept)
            begin
                elev_count_reg  <= elev_count_next;
                ail_count_reg   <= ail_count_next;
                elev_width_reg  <= elev_width_next;
                ail_width_reg   <= ail_width_next;
                frame_count_reg <= frame_count_next;
                left_width_reg  <= left_width_next;
                right_width_reg <= right_width_next;
                left_level_reg  <= left_level_next;
                right_level_reg <= right_level_next;
                out_valid_reg   <= 1'b1;
            end
            else if (drive.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> drive.valid)
        else $error("accepted item did not reach the output register");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (out_valid_reg && !drive.ready))
        else $error("input stalled with room in the output register");

    a_frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && wrap) |=> (frame_count_reg == '0))
        else $error("frame counter failed to wrap");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sample.elevator_level && elev_count_reg == COUNT_MAX)
        |=> (elev_count_reg == COUNT_MAX))
        else $error("elevator high count did not saturate");
`endif

endmodule

[sim/testbench.sv]
// Self-checking testbench for the servo pulse elevon mixer, with a tick-by-tick pin predictor.

class elevon_tracker;
    typedef struct packed {
        logic left;
        logic right;
    } pin_pair_t;

    spm_pkg::tick_t frame_ticks;
    spm_pkg::tick_t pulse_min;
    spm_pkg::tick_t pulse_max;
    spm_pkg::tick_t pulse_center;

    spm_pkg::tick_t elev_run;
    spm_pkg::tick_t ail_run;
    spm_pkg::tick_t elev_width;
    spm_pkg::tick_t ail_width;
    spm_pkg::tick_t frame_pos;
    spm_pkg::mix_t  left_width;
    spm_pkg::mix_t  right_width;

    pin_pair_t pins_due[$];
    int        failures;
    int        checked;
    int        samples;
    int        writes;

    function new();
        frame_ticks  = spm_pkg::FRAME_TICKS_RST;
        pulse_min    = spm_pkg::PULSE_MIN_RST;
        pulse_max    = spm_pkg::PULSE_MAX_RST;
        pulse_center = spm_pkg::PULSE_CENTER_RST;
        elev_run     = '0;
        ail_run      = '0;
        elev_width   = '0;
        ail_width    = '0;
        frame_pos    = '0;
        left_width   = '0;
        right_width  = '0;
        failures     = 0;
        checked      = 0;
        samples      = 0;
        writes       = 0;
    endfunction

    function void write_reg(spm_pkg::cfg_index_t index, spm_pkg::tick_t data);
        writes++;
        case (index)
            spm_pkg::REG_FRAME_TICKS:  frame_ticks  = data;
            spm_pkg::REG_PULSE_MIN:    pulse_min    = data;
            spm_pkg::REG_PULSE_MAX:    pulse_max    = data;
            spm_pkg::REG_PULSE_CENTER: pulse_center = data;
            default: ;
        endcase
    endfunction

    function void track_pulse(logic level, inout spm_pkg::tick_t run,
                              inout spm_pkg::tick_t width);
        if (level)
        begin
            if (run != spm_pkg::COUNT_MAX)
                run++;
        end
        else if (run != '0)
        begin
            width = run;
            run   = '0;
        end
    endfunction

    function spm_pkg::mix_t clamp_mix(int v);
        return (v < 0) ? '0 : spm_pkg::mix_t'(v);
    endfunction

    function void mix_widths();
        int c;
        int ew;
        int aw;
        int he;
        int ha;
        if (elev_width >= pulse_min && elev_width <= pulse_max &&
            ail_width >= pulse_min && ail_width <= pulse_max)
        begin
            c  = pulse_center;
            ew = elev_width;
            aw = ail_width;
            // Integer division truncates toward zero, which is the halving wanted here.
            he = (ew - c) / 2;
            ha = (aw - c) / 2;
            left_width  = clamp_mix(he + ha + c);
            right_width = clamp_mix(he - ha + c);
        end
        else
        begin
            left_width  = '0;
            right_width = '0;
        end
    endfunction

    function void note_tick(logic elevator, logic aileron);
        spm_pkg::tick_t next_pos;
        pin_pair_t      pins;
        samples++;
        track_pulse(elevator, elev_run, elev_width);
        track_pulse(aileron, ail_run, ail_width);
        next_pos = frame_pos + 16'd1;
        if (next_pos == frame_ticks)
        begin
            frame_pos = '0;
            mix_widths();
        end
        else
            frame_pos = next_pos;
        pins.left  = ({1'b0, frame_pos} < left_width);
        pins.right = ({1'b0, frame_pos} < right_width);
        pins_due.push_back(pins);
    endfunction

    function void check_pins(logic left, logic right);
        pin_pair_t want;
        if (pins_due.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("unexpected output item: left %0b right %0b", left, right);
            return;
        end
        want = pins_due.pop_front();
        checked++;
        if (want.left !== left || want.right !== right)
        begin
            failures++;
            if (failures <= 10)
                $display("output item %0d: expected left %0b right %0b, got left %0b right %0b",
                         checked, want.left, want.right, left, right);
        end
    endfunction
endclass

module testbench;
    import spm_pkg::*;

    localparam int         LIMIT      = 5_000_000;
    localparam cfg_index_t REG_UNUSED = 8'hFF;

    // Directed ticks, two bits each as {elevator, aileron}, first item in the top bits.
    localparam logic [47:0] DIRECTED_TICKS =
        48'b11_01_01_01_01_01_01_01_01_00_10_10_10_11_00_10_10_00_01_00_11_11_11_00;

    typedef enum {ELEV_FREE, ELEV_HIGH, ELEV_LOW} elev_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    int   cycles = 0;
    int   burst_left;
    logic level_now [2];
    int   span_left [2];

    elevon_tracker sb;

    spm_sample_if sample_ch ();
    spm_drive_if  drive_ch ();
    spm_cfg_if    cfg_ch ();

    servo_pulse_elevon_mixer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .drive  (drive_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timed out after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // The receiver changes its manner in turn through four phases: always ready, random stalls,
    // ready one cycle in three, or short runs of stalls.
    always @(posedge clk)
    begin
        case (cycles[8:7])
            2'd0: drive_ch.ready <= 1'b1;
            2'd1: drive_ch.ready <= ($urandom_range(3, 0) != 0);
            2'd2: drive_ch.ready <= ((cycles % 3) == 0);
            default: drive_ch.ready <= (cycles[3:0] < 4'd11);
        endcase
    end

    always @(posedge clk)
    begin
        if (cfg_ch.valid && cfg_ch.ready)
            sb.write_reg(cfg_ch.index, cfg_ch.data);
        if (sample_ch.valid && sample_ch.ready)
            sb.note_tick(sample_ch.elevator_level, sample_ch.aileron_level);
        if (drive_ch.valid && drive_ch.ready)
            sb.check_pins(drive_ch.left_level, drive_ch.right_level);
    end

    task automatic send_tick(input logic elevator, input logic aileron);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(4, 1);
            if (gap != 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(24, 1);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.elevator_level <= elevator;
        sample_ch.aileron_level  <= aileron;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        burst_left--;
    endtask

    // Pulse trains: high spans mostly within lo..hi, now and then anywhere from 1 to 3*hi+3.
    function automatic logic next_level(input int ch, input int lo, input int hi);
        if (span_left[ch] == 0)
        begin
            level_now[ch] = !level_now[ch];
            if (level_now[ch])
                span_left[ch] = ($urandom_range(9, 0) == 0) ? $urandom_range(3 * hi + 3, 1)
                                                            : $urandom_range(hi, lo);
            else
                span_left[ch] = $urandom_range(10, 1);
        end
        span_left[ch]--;
        return level_now[ch];
    endfunction

    task automatic pulse_ticks(input int n, input int lo, input int hi, input elev_mode_t mode);
        logic elevator;
        logic aileron;
        repeat (n)
        begin
            case (mode)
                ELEV_HIGH: elevator = 1'b1;
                ELEV_LOW:  elevator = 1'b0;
                default:   elevator = next_level(0, lo, hi);
            endcase
            aileron = next_level(1, lo, hi);
            send_tick(elevator, aileron);
        end
    endtask

    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pins_due.size() != 0);
    endtask

    // Runs on to the next wrap, so that the frame counter stands at zero afterwards.
    task automatic finish_frame(input int lo, input int hi, input elev_mode_t mode);
        tick_t remaining;
        int    n;
        wait_drained();
        remaining = sb.frame_ticks - sb.frame_pos;
        n = (remaining == '0) ? 65536 : int'(remaining);
        pulse_ticks(n, lo, hi, mode);
    endtask

    task automatic write_regs(input tick_t frame, input tick_t lo_lim, input tick_t hi_lim,
                              input tick_t centre, input bit poke_unused);
        cfg_index_t idx [5];
        tick_t      val [5];
        int         n;
        idx[0] = REG_FRAME_TICKS;
        idx[1] = REG_PULSE_MIN;
        idx[2] = REG_PULSE_MAX;
        idx[3] = REG_PULSE_CENTER;
        idx[4] = REG_UNUSED;
        val[0] = frame;
        val[1] = lo_lim;
        val[2] = hi_lim;
        val[3] = centre;
        val[4] = 16'hFFFF;
        n = poke_unused ? 5 : 4;
        for (int i = 0; i < n; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        tick_t frame;
        tick_t lo_lim;
        tick_t hi_lim;
        tick_t centre;
        int    lo;
        int    hi;

        sb = new();
        burst_left   = 0;
        level_now[0] = 1'b0;
        level_now[1] = 1'b0;
        span_left[0] = 0;
        span_left[1] = 0;

        rst_n                    <= 1'b0;
        sample_ch.valid          <= 1'b0;
        sample_ch.elevator_level <= 1'b0;
        sample_ch.aileron_level  <= 1'b0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.index             <= '0;
        cfg_ch.data              <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // One-tick frames remix on every item, so each latched width shows at once:
        // truncation of odd negative halves and a negative right mix clamped to zero.
        write_regs(16'd1, 16'd1, 16'd12, 16'd3, 1'b1);
        for (int i = 0; i < 24; i++)
            send_tick(DIRECTED_TICKS[47 - 2 * i], DIRECTED_TICKS[46 - 2 * i]);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    frame = 16'd24; lo_lim = 16'd3; hi_lim = 16'd9; centre = 16'd6;
                end
                1:
                begin
                    frame = 16'd37; lo_lim = 16'd2; hi_lim = 16'd14; centre = 16'd8;
                end
                2:
                begin
                    // Crossed limits: no width can pass.
                    frame = 16'd16; lo_lim = 16'hFFFF; hi_lim = 16'd0; centre = 16'd6;
                end
                3:
                begin
                    // Centre at the top of its range drives the right mix very high.
                    frame = 16'd50; lo_lim = 16'd0; hi_lim = 16'hFFFF; centre = 16'hFFFF;
                end
                default:
                begin
                    frame  = tick_t'($urandom_range(64, 8));
                    lo_lim = tick_t'($urandom_range(6, 1));
                    hi_lim = tick_t'($urandom_range(16, int'(lo_lim) + 2));
                    centre = tick_t'($urandom_range(20, 0));
                end
            endcase
            if (hi_lim > 16'd40 || lo_lim > hi_lim)
            begin
                lo = 1;
                hi = 12;
            end
            else
            begin
                lo = (lo_lim > 16'd1) ? int'(lo_lim) - 1 : 1;
                hi = int'(hi_lim) + 1;
            end
            wait_drained();
            write_regs(frame, lo_lim, hi_lim, centre, 1'b0);
            pulse_ticks(150, lo, hi, ELEV_FREE);
            finish_frame(lo, hi, ELEV_FREE);
        end

        wait_drained();
        repeat (8) @(posedge clk);

        $display("%0d sample ticks sent, %0d pin pairs checked, %0d register writes",
                 sb.samples, sb.checked, sb.writes);
        $display("included one-tick frames, crossed and open limits, and clamped mixes");
        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[servo_pulse_elevon_mixer.f]
hdl/spm_pkg.sv
hdl/spm_sample_if.sv
hdl/spm_drive_if.sv
hdl/spm_cfg_if.sv
hdl/servo_pulse_elevon_mixer.sv
sim/testbench.sv
